// ===== hw/rtl/dpbd_pkg.sv =====
// Shared constants and types for the dew point and breath detector.
// Used by dpbd_div, dew_point_breath_detector and dpbd_checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package dpbd_pkg;

	// Field widths.
	localparam int TEMP_W = 18;
	localparam int RH_W   = 17;
	localparam int THR_W  = 17;
	localparam int REF_W  = 19;
	localparam int DEW_W  = 18;
	localparam int CAL_W  = 2;

	// Calibration length and register reset value.
	localparam int unsigned CAL_SAMPLES_DEF = 3;
	localparam logic [THR_W-1:0] THR_RESET = 17'd100;

	// Serial divider sizing.
	localparam int DIV_NUM_W = 54;
	localparam int DIV_DEN_W = 37;

	// Log unit: Q30 mantissa squared once per cycle for each fraction bit.
	localparam int M_W     = 31;
	localparam int FRAC_W  = 24;
	localparam int LOG_ITER = 24;
	localparam int LCNT_W  = 5;
	localparam logic signed [29:0] LOG2_1E5_Q24 = 30'sd278663526;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Magnus constants in fixed point.
	localparam logic [10:0] TEMP_COEF = 11'd1762;
	localparam logic [17:0] TEMP_OFS  = 18'd243120;
	localparam logic [24:0] DEW_COEF  = 25'd24312000;
	localparam logic signed [39:0] DEN_BASE = 40'sd29561454592;

	// Saturation limits of the dew point.
	localparam logic signed [DEW_W-1:0] DEW_MIN = -18'sd100000;
	localparam logic signed [DEW_W-1:0] DEW_MAX = 18'sd125000;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_CAL  = 2'd0,
		KIND_MEAS = 2'd1,
		KIND_FAIL = 2'd2
	} kind_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dpbd_div.sv =====
// Bit-serial restoring divider with round-to-nearest, one quotient bit per cycle.
// Depends on dpbd_pkg for its default widths.
`timescale 1ns / 1ps
`default_nettype none
module dpbd_div #(
	parameter int NUM_W = dpbd_pkg::DIV_NUM_W,
	parameter int DEN_W = dpbd_pkg::DIV_DEN_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] dvd_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic [DEN_W:0]   shifted;
	logic             ge;
	logic [DEN_W:0]   diff;

	// One trial subtraction per cycle.
	always_comb begin
		shifted = {rem_q, dvd_q[NUM_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// Dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num + NUM_W'(den >> 1);
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			dvd_q <= {dvd_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign busy = run_q;
	assign quot = dvd_q;
endmodule
`default_nettype wire

// ===== hw/rtl/dew_point_breath_detector.sv =====
// Top level of the dew point and breath detector: control, log unit and touch flag.
// Depends on dpbd_pkg and instantiates dpbd_div.
//
//  Channel  | Direction | Signals                         | Contents (lowest bit first)
//  s_axis   | in        | s_tvalid s_tready s_tdata s_tuser | temp_milli, rh_milli, button / read_ok
//  m_axis   | out       | m_tvalid m_tready m_tdata m_tuser | dew_milli, touch / result_kind, dew_valid
//  cfg      | in        | cfg_wr_en cfg_wr_data           | touch_threshold
//
// Calibration samples, failed readings and zero humidity go via ST_PUSH to the output register.
// After acceptance a measurement runs the temperature division (the log squaring runs beside it),
// forms the log term and the sum, starts the shared divider, runs the dew point division,
// then writes the result and loads the output register.
// One item is worked at a time; s_tready is high only when the control is idle.
// A finished result waits in the output register while the next item is taken; if it is
// still not taken when the next result is ready, the block holds. Reset is asynchronous.
`timescale 1ns / 1ps
`default_nettype none
module dew_point_breath_detector #(
	parameter int unsigned CAL_SAMPLES = dpbd_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // temp_milli[17:0], rh_milli[34:18], button_pressed[35]
	input  wire logic        s_tuser,   // read_ok[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // dew_milli[17:0], touch[18]
	output logic [2:0]       m_tuser,   // result_kind[1:0], dew_valid[2]
	input  wire logic        cfg_wr_en,
	input  wire logic [16:0] cfg_wr_data // touch_threshold[16:0]
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_LOG, ST_K, ST_D2, ST_D2W, ST_PUSH
	} state_t;

	localparam int TW = dpbd_pkg::TEMP_W;
	localparam int RW = dpbd_pkg::RH_W;
	localparam int NW = dpbd_pkg::DIV_NUM_W;
	localparam int DW = dpbd_pkg::DIV_DEN_W;

	state_t state_q;

	logic [dpbd_pkg::THR_W-1:0] thr_q;
	logic [dpbd_pkg::REF_W-1:0] ref_q;
	logic [dpbd_pkg::CAL_W-1:0] cal_q;

	dpbd_pkg::kind_t               res_kind_q;
	logic signed [dpbd_pkg::DEW_W-1:0] res_dew_q;
	logic                          res_dvalid_q;
	logic                          res_touch_q;

	logic                          out_valid_q;
	dpbd_pkg::kind_t               out_kind_q;
	logic signed [dpbd_pkg::DEW_W-1:0] out_dew_q;
	logic                          out_dvalid_q;
	logic                          out_touch_q;

	logic [dpbd_pkg::M_W-1:0]    m_q;
	logic [dpbd_pkg::FRAC_W-1:0] frac_q;
	logic [4:0]                  e_q;
	logic [dpbd_pkg::LCNT_W-1:0] lcnt_q;
	logic                        t_neg_q;
	logic signed [29:0]          lnq_q;
	logic signed [29:0]          tq_q;
	logic signed [30:0]          k_q;

	// Shared serial divider signals.
	logic          div_start;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic          div_busy;
	logic [NW-1:0] div_quot;

	// Input fields.
	logic signed [TW-1:0] t_in;
	logic [RW-1:0]        rh_in;
	logic                 btn_in;
	logic                 ok_in;
	logic                 accept;

	assign t_in   = s_tdata[17:0];
	assign rh_in  = s_tdata[34:18];
	assign btn_in = s_tdata[35];
	assign ok_in  = s_tuser;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// Decision on the incoming reading.
	logic start_cal;
	logic go_meas;
	logic [dpbd_pkg::REF_W-1:0] rh3;
	logic [dpbd_pkg::REF_W-1:0] thr3;
	logic signed [20:0]         rise;
	logic                       touch_in;

	always_comb begin
		start_cal = (cal_q == '0) && ((ref_q == '0) || btn_in);
		go_meas   = !start_cal && (cal_q == '0) && ok_in && (rh_in != '0);
		rh3       = dpbd_pkg::REF_W'(CAL_SAMPLES * 32'(rh_in));
		thr3      = dpbd_pkg::REF_W'(CAL_SAMPLES * 32'(thr_q));
		rise      = $signed({2'b00, rh3}) - $signed({2'b00, ref_q});
		touch_in  = rise > $signed({2'b00, thr3});
	end

	// Leading one of the humidity and the normalised mantissa.
	logic [4:0]               e_in;
	logic [dpbd_pkg::M_W-1:0] m_init;

	always_comb begin
		e_in = '0;
		for (int i = 1; i < RW; i++) begin
			if (rh_in[i]) begin
				e_in = 5'(i);
			end
		end
		m_init = dpbd_pkg::M_W'(rh_in) << (5'd30 - e_in);
	end

	// Temperature division operands.
	logic [TW-1:0]  t_abs;
	logic [28:0]    t_prod;
	logic [19:0]    t_sum;
	logic [NW-1:0]  num1;
	logic [DW-1:0]  den1;

	always_comb begin
		t_abs  = t_in[TW-1] ? TW'(-t_in) : TW'(t_in);
		t_prod = 29'(dpbd_pkg::TEMP_COEF) * 29'(t_abs);
		t_sum  = 20'($signed({2'b00, dpbd_pkg::TEMP_OFS}) + 20'(t_in));
		num1   = NW'({t_prod, 24'd0});
		den1   = DW'(t_sum[18:0]) * DW'(7'd100);
	end

	// Log squaring step.
	logic [61:0] sq;
	logic [31:0] m2;

	always_comb begin
		sq = 62'(m_q) * 62'(m_q);
		m2 = sq[61:30];
	end

	// Natural log term from the log2 result.
	logic signed [29:0] l_val;
	logic [28:0]        l_mag;
	logic [61:0]        ln_prod;
	logic [29:0]        ln_mag;
	logic [28:0]        tq_mag;

	always_comb begin
		l_val   = $signed({1'b0, e_q, frac_q}) - dpbd_pkg::LOG2_1E5_Q24;
		l_mag   = l_val[29] ? 29'(-l_val) : 29'(l_val);
		ln_prod = 62'(l_mag) * 62'(dpbd_pkg::LN2_Q32) + 62'(33'h080000000);
		ln_mag  = ln_prod[61:32];
		tq_mag  = div_quot[28:0];
	end

	// Dew point division operands.
	logic [29:0]        k_mag;
	logic signed [39:0] k_ext;
	logic signed [39:0] den2_full;
	logic [NW-1:0]      num2;
	logic [DW-1:0]      den2;

	always_comb begin
		k_mag     = k_q[30] ? 30'(-k_q) : 30'(k_q);
		k_ext     = 40'(k_q);
		den2_full = dpbd_pkg::DEN_BASE - k_ext * 40'sd100;
		num2      = NW'(55'(dpbd_pkg::DEW_COEF) * 55'(k_mag));
		den2      = den2_full[DW-1:0];
	end

	// Shared serial divider.
	always_comb begin
		div_start = (accept && go_meas) || (state_q == ST_D2);
		div_num   = (state_q == ST_IDLE) ? num1 : num2;
		div_den   = (state_q == ST_IDLE) ? den1 : den2;
	end

	dpbd_div #(
		.NUM_W(NW),
		.DEN_W(DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Saturated dew point from the final quotient.
	logic signed [dpbd_pkg::DEW_W-1:0] dew_sat;

	always_comb begin
		if (k_q[30]) begin
			dew_sat = (div_quot > NW'(100000)) ? dpbd_pkg::DEW_MIN
			        : dpbd_pkg::DEW_W'(-div_quot[dpbd_pkg::DEW_W-1:0]);
		end else begin
			dew_sat = (div_quot > NW'(125000)) ? dpbd_pkg::DEW_MAX
			        : $signed(div_quot[dpbd_pkg::DEW_W-1:0]);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= dpbd_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Main sequencer with reference state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ref_q        <= '0;
			cal_q        <= '0;
			res_kind_q   <= dpbd_pkg::KIND_CAL;
			res_dew_q    <= '0;
			res_dvalid_q <= 1'b0;
			res_touch_q  <= 1'b0;
			lcnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_dew_q    <= '0;
						res_dvalid_q <= 1'b0;
						res_touch_q  <= 1'b0;
						state_q      <= ST_PUSH;
						if (start_cal) begin
							ref_q      <= dpbd_pkg::REF_W'(rh_in);
							cal_q      <= dpbd_pkg::CAL_W'(CAL_SAMPLES - 1);
							res_kind_q <= dpbd_pkg::KIND_CAL;
						end else if (cal_q != '0) begin
							ref_q      <= ref_q + dpbd_pkg::REF_W'(rh_in);
							cal_q      <= cal_q - 1'b1;
							res_kind_q <= dpbd_pkg::KIND_CAL;
						end else if (ok_in) begin
							res_kind_q  <= dpbd_pkg::KIND_MEAS;
							res_touch_q <= touch_in;
							if (rh_in == '0) begin
								res_dew_q <= dpbd_pkg::DEW_MIN;
							end else begin
								lcnt_q  <= dpbd_pkg::LCNT_W'(dpbd_pkg::LOG_ITER);
								state_q <= ST_LOG;
							end
						end else begin
							res_kind_q <= dpbd_pkg::KIND_FAIL;
						end
					end
				end
				ST_LOG: begin
					if (lcnt_q != '0) begin
						lcnt_q <= lcnt_q - 1'b1;
					end else if (!div_busy) begin
						state_q <= ST_K;
					end
				end
				ST_K: begin
					state_q <= ST_D2;
				end
				ST_D2: begin
					state_q <= ST_D2W;
				end
				ST_D2W: begin
					if (!div_busy) begin
						res_dew_q    <= dew_sat;
						res_dvalid_q <= 1'b1;
						state_q      <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the log unit and the Magnus sums.
	always_ff @(posedge clk) begin
		if (accept && go_meas) begin
			m_q     <= m_init;
			e_q     <= e_in;
			frac_q  <= '0;
			t_neg_q <= t_in[TW-1];
		end else if (state_q == ST_LOG && lcnt_q != '0) begin
			m_q    <= m2[31] ? m2[31:1] : m2[30:0];
			frac_q <= {frac_q[dpbd_pkg::FRAC_W-2:0], m2[31]};
		end
		if (state_q == ST_LOG && lcnt_q == '0 && !div_busy) begin
			lnq_q <= l_val[29] ? -$signed(ln_mag) : $signed(ln_mag);
			tq_q  <= t_neg_q ? -$signed({1'b0, tq_mag}) : $signed({1'b0, tq_mag});
		end
		if (state_q == ST_K) begin
			k_q <= 31'(lnq_q) + 31'(tq_q);
		end
	end

	// Output register: holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && (!out_valid_q || m_tready)) begin
			out_kind_q   <= res_kind_q;
			out_dew_q    <= res_dew_q;
			out_dvalid_q <= res_dvalid_q;
			out_touch_q  <= res_touch_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_touch_q, out_dew_q};
	assign m_tuser  = {out_dvalid_q, out_kind_q};
endmodule
`default_nettype wire

// ===== verif/dpbd_checker.sv =====
// Checker for the dew point and breath detector: watches the input, output and register ports,
// predicts each result from its own copy of the calibration state, and counts mismatches.
// Depends on dpbd_pkg for field widths and result kinds.
`timescale 1ns / 1ps
module dpbd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data,
	output int          errors,
	output int          outstanding
);
	typedef struct packed {
		dpbd_pkg::kind_t                   kind;
		logic signed [dpbd_pkg::DEW_W-1:0] dew;
		logic                              valid;
		logic                              touch;
	} reading_t;

	reading_t                   readings_due[$];
	logic [dpbd_pkg::THR_W-1:0] threshold;
	logic [dpbd_pkg::REF_W-1:0] humidity_ref;
	logic [dpbd_pkg::CAL_W-1:0] cal_left;

	// Round to nearest, halves away from zero.
	function automatic longint round_div(longint num, longint den);
		if (num >= 0) begin
			return (num + den / 2) / den;
		end
		return -((-num + den / 2) / den);
	endfunction

	// log2 of the humidity in Q24, fraction by repeated squaring of a Q30 mantissa.
	function automatic longint rh_log2(int unsigned x);
		int                e;
		longint unsigned   mant;
		longint            frac;
		e = 16;
		frac = 0;
		while (e > 0 && x[e] == 1'b0) begin
			e--;
		end
		mant = longint'(x) << (30 - e);
		for (int i = 0; i < 24; i++) begin
			mant = (mant * mant) >> 30;
			frac = frac << 1;
			if (mant >= (64'd2 << 30)) begin
				frac = frac | 1;
				mant = mant >> 1;
			end
		end
		return (longint'(e) << 24) + frac;
	endfunction

	// Magnus dew point in millidegrees, saturated to the output range.
	function automatic longint magnus_dew(longint t, int unsigned rh);
		longint          l, lnq, tq, k, den, dew;
		longint unsigned mag;
		l = rh_log2(rh) - 64'sd278663526;
		mag = (l < 0) ? -l : l;
		lnq = longint'((mag * 64'd2977044472 + (64'd1 << 31)) >> 32);
		if (l < 0) begin
			lnq = -lnq;
		end
		tq = round_div(1762 * t * (64'sd1 << 24), 100 * (243120 + t));
		k = lnq + tq;
		den = 1762 * (64'sd1 << 24) - 100 * k;
		if (den <= 0) begin
			return 125000;
		end
		dew = round_div(24312000 * k, den);
		if (dew < -100000) begin
			dew = -100000;
		end
		if (dew > 125000) begin
			dew = 125000;
		end
		return dew;
	endfunction

	// Prediction on each accepted reading, comparison on each accepted result.
	always @(posedge clk or negedge arst_n) begin
		reading_t    exp_r;
		reading_t    got;
		longint      t;
		int unsigned rh;
		longint      rise;
		if (!arst_n) begin
			threshold    <= dpbd_pkg::THR_RESET;
			humidity_ref <= '0;
			cal_left     <= '0;
			readings_due.delete();
			errors       <= 0;
			outstanding  <= 0;
		end else begin
			if (cfg_wr_en) begin
				threshold <= cfg_wr_data;
			end
			if (s_tvalid && s_tready) begin
				t  = longint'($signed(s_tdata[17:0]));
				rh = s_tdata[34:18];
				exp_r = '{kind: dpbd_pkg::KIND_CAL, dew: '0, valid: 1'b0, touch: 1'b0};
				if (cal_left == 0 && (humidity_ref == 0 || s_tdata[35])) begin
					humidity_ref <= dpbd_pkg::REF_W'(rh);
					cal_left     <= dpbd_pkg::CAL_W'(dpbd_pkg::CAL_SAMPLES_DEF - 1);
				end else if (cal_left != 0) begin
					humidity_ref <= humidity_ref + dpbd_pkg::REF_W'(rh);
					cal_left     <= cal_left - 1'b1;
				end else if (s_tuser) begin
					exp_r.kind  = dpbd_pkg::KIND_MEAS;
					rise        = longint'(dpbd_pkg::CAL_SAMPLES_DEF) * longint'(rh)
						- longint'(humidity_ref);
					exp_r.touch = rise > longint'(dpbd_pkg::CAL_SAMPLES_DEF)
						* longint'(threshold);
					if (rh == 0) begin
						exp_r.dew = dpbd_pkg::DEW_MIN;
					end else begin
						exp_r.dew   = dpbd_pkg::DEW_W'(magnus_dew(t, rh));
						exp_r.valid = 1'b1;
					end
				end else begin
					exp_r.kind = dpbd_pkg::KIND_FAIL;
				end
				readings_due.push_back(exp_r);
			end
			if (m_tvalid && m_tready) begin
				got = '{kind: dpbd_pkg::kind_t'(m_tuser[1:0]), dew: m_tdata[17:0],
					valid: m_tuser[2], touch: m_tdata[18]};
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					errors <= errors + 1;
				end else begin
					exp_r = readings_due.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
						errors <= errors + 1;
					end
				end
			end
			outstanding <= readings_due.size();
		end
	end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the dew point and breath detector: clock, reset, readings, register
// writes and output back-pressure. Depends on dpbd_pkg, dpbd_checker and the block itself.
`timescale 1ns / 1ps
module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_wr_en = 1'b0;
	logic [16:0] cfg_wr_data = '0;
	int          errors;
	int          outstanding;
	int          idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_req = 1'b0;
	int          hold_left = 0;
	int          cycles = 0;

	dew_point_breath_detector dut (.*);
	dpbd_checker u_checker (.*);

	always #5 clk = ~clk;

	// Receiver back-pressure, with one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left <= 600;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= stall_pct;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one reading and wait until the block takes it.
	task automatic send_reading(logic signed [17:0] temp, logic [16:0] rh, logic ok, logic btn);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, btn, rh, temp};
		s_tuser  <= ok;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_reading();
		logic signed [17:0] temp;
		logic [16:0]        rh;
		temp = ($urandom_range(9) == 0) ? 18'($urandom) : 18'($urandom_range(165000) - 40000);
		rh   = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(100000));
		if ($urandom_range(19) == 0) begin
			rh = 17'($urandom_range(3));
		end
		send_reading(temp, rh, $urandom_range(9) != 0, $urandom_range(14) == 0);
	endtask

	// Register write while the block is idle.
	task automatic set_threshold(logic [16:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (150) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int          phase_idle [4];
		int          phase_stall[4];
		logic [16:0] thr[4];
		phase_idle  = '{0, 83, 0, 38};
		phase_stall = '{0, 0, 83, 38};
		thr         = '{17'd0, 17'd100000, 17'd131071, 17'd500};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Calibration on an all-zero reference, then a fresh one on the next reading.
		repeat (3) send_reading(18'sd20000, 17'd0, 1'b0, 1'b0);
		send_reading(18'sd20000, 17'd40000, 1'b1, 1'b0);
		send_reading(18'sd20000, 17'd41000, 1'b0, 1'b1);
		send_reading(18'sd20000, 17'd42000, 1'b1, 1'b0);
		// Extremes of temperature and humidity, failed reading, zero humidity.
		send_reading(-18'sd40000, 17'd100000, 1'b1, 1'b0);
		send_reading(18'sd125000, 17'd1, 1'b1, 1'b0);
		send_reading(-18'sd131072, 17'd131071, 1'b1, 1'b0);
		send_reading(18'sd131071, 17'd100000, 1'b1, 1'b0);
		send_reading(18'sd0, 17'd0, 1'b1, 1'b0);
		send_reading(18'sd25000, 17'd60000, 1'b0, 1'b0);
		send_reading(18'sd25000, 17'd99000, 1'b1, 1'b0);
		send_reading(-18'sd1, 17'd50, 1'b1, 1'b0);
		// Button-requested recalibration while idle.
		send_reading(18'sd22000, 17'd30000, 1'b1, 1'b1);
		send_reading(18'sd22000, 17'd30000, 1'b0, 1'b1);
		send_reading(18'sd22000, 17'd30000, 1'b1, 1'b0);
		send_reading(18'sd22000, 17'd90000, 1'b1, 1'b0);

		// Random phases, each with its own threshold and idling pattern.
		for (int p = 0; p < 4; p++) begin
			set_threshold(thr[p]);
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int i = 0; i < 330; i++) begin
				if (p == 0 && i == 40) begin
					hold_req <= 1'b1;
				end
				if (p == 0 && i == 41) begin
					hold_req <= 1'b0;
				end
				random_reading();
			end
		end
		s_tvalid <= 1'b0;
		stall_pct = 0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
